// ----- hw/rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared sizes, payload types and request and status codes.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SLOTS     = 64;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int GEN_BITS  = 16;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [GEN_BITS-1:0]  gen_type;

   // Request codes. The reserved code behaves as a check.
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_STALE = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      slot_type   slot_index;
      gen_type    handle_generation;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      slot_type   out_slot;
      gen_type    out_generation;
      logic       is_alive;
   } rsp_payload_type;

   // Commands from the control logic to the slot table.
   typedef struct packed {
      logic     rd_en;
      slot_type rd_addr;
      logic     alive_set;
      logic     alive_clr;
      logic     gen_wr_en;
      slot_type wr_addr;
      gen_type  wr_gen;
   } tbl_cmd_type;

   // Status returned by the slot table.
   typedef struct packed {
      logic     free_found;
      slot_type free_slot;
      logic     rd_alive;
      gen_type  rd_gen;
   } tbl_sts_type;

endpackage

// ----- hw/rtl/gha_if.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface gha_req_if;
   import gha_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gha_rsp_if;
   import gha_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gha_slot_table.sv -----
// ----------------------------------------------------------------------------
// Slot table
// Alive flags, lowest-free-slot search and the generation memory.
// ----------------------------------------------------------------------------
module gha_slot_table (
   input  logic                clock,
   input  logic                reset,
   input  gha_pkg::tbl_cmd_type cmd,
   output gha_pkg::tbl_sts_type sts
);
   import gha_pkg::*;

   logic [SLOTS-1:0] alive_ff;
   logic [SLOTS-1:0] gen_vld_ff;
   gen_type          gen_mem [SLOTS];
   gen_type          rd_gen_ff;
   logic             rd_vld_ff;
   logic             rd_alive_ff;
   logic             free_found;
   slot_type         free_slot;

   // Lowest slot whose alive flag is clear.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!alive_ff[i]) begin
            free_found = 1'b1;
            free_slot  = slot_type'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff   <= '0;
         gen_vld_ff <= '0;
      end else begin
         if (cmd.alive_set) begin
            alive_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.alive_clr) begin
            alive_ff[cmd.wr_addr] <= 1'b0;
         end
         if (cmd.gen_wr_en) begin
            gen_vld_ff[cmd.wr_addr] <= 1'b1;
         end
      end
   end

   // Generation memory: one write port, one registered read port.
   // An entry that was never written reads as zero through its valid bit.
   always_ff @(posedge clock) begin
      if (cmd.gen_wr_en) begin
         gen_mem[cmd.wr_addr] <= cmd.wr_gen;
      end
      if (cmd.rd_en) begin
         rd_gen_ff   <= gen_mem[cmd.rd_addr];
         rd_vld_ff   <= gen_vld_ff[cmd.rd_addr];
         rd_alive_ff <= alive_ff[cmd.rd_addr];
      end
   end

   assign sts.free_found = free_found;
   assign sts.free_slot  = free_slot;
   assign sts.rd_alive   = rd_alive_ff;
   assign sts.rd_gen     = rd_vld_ff ? rd_gen_ff : '0;

endmodule

// ----- hw/rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out slot handles with generation counts, frees and checks them.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake      Payload
//   req_chan   in         valid/ready    req_type, slot_index, handle_generation
//   rsp_chan   out        valid/ready    status, out_slot, out_generation, is_alive
//
// Each request first reads the generation memory, then evaluates the handle,
// writes back and loads the response register. The generation memory has a
// single registered read port.
// The response register lets a new request be taken while an earlier
// response waits; the evaluate cycle stalls only if that register is full.
// After reset all slots are free with generation zero at once; there is no
// clearing pass.
//
module generational_handle_allocator (
   input logic      clock,
   input logic      reset,
   gha_req_if.sink   req_chan,
   gha_rsp_if.source rsp_chan
);
   import gha_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type       state_ff, state_in;
   req_payload_type req_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tbl_cmd_type     tbl_cmd;
   tbl_sts_type     tbl_sts;
   logic            accept;
   logic            commit;
   logic            is_create;
   logic            is_delete;
   logic            handle_ok;
   gen_type         next_gen;

   gha_slot_table u_slot_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .sts   (tbl_sts)
   );

   // A request is taken only in idle, so the read issued on a transfer and
   // the write-back of the previous request never touch the memory in the
   // same cycle. No forwarding is needed.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // The response register must be empty, or be emptied this cycle.
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign is_create = (req_ff.req_type == REQ_CREATE);
   assign is_delete = (req_ff.req_type == REQ_DELETE);
   assign handle_ok = tbl_sts.rd_alive && (tbl_sts.rd_gen == req_ff.handle_generation);
   assign next_gen  = tbl_sts.rd_gen + gen_type'(1);

   always_comb begin
      tbl_cmd.rd_en     = accept;
      tbl_cmd.rd_addr   = (req_chan.data.req_type == REQ_CREATE) ? tbl_sts.free_slot
                                                                 : req_chan.data.slot_index;
      tbl_cmd.alive_set = commit && is_create && tbl_sts.free_found;
      tbl_cmd.alive_clr = commit && is_delete && handle_ok;
      tbl_cmd.gen_wr_en = commit && is_delete && handle_ok;
      tbl_cmd.wr_addr   = is_create ? tbl_sts.free_slot : req_ff.slot_index;
      tbl_cmd.wr_gen    = next_gen;
   end

   // Build the response. The alive flags do not change between the read and
   // this cycle, so the free-slot search still points at the slot just read.
   always_comb begin
      rsp_data_in = '0;
      if (is_create) begin
         if (tbl_sts.free_found) begin
            rsp_data_in.status         = STAT_DONE;
            rsp_data_in.out_slot       = tbl_sts.free_slot;
            rsp_data_in.out_generation = tbl_sts.rd_gen;
         end else begin
            rsp_data_in.status = STAT_FULL;
         end
      end else begin
         rsp_data_in.out_slot       = req_ff.slot_index;
         rsp_data_in.is_alive       = handle_ok;
         rsp_data_in.status         = handle_ok ? STAT_DONE : STAT_STALE;
         // A successful delete reports the generation after the bump.
         rsp_data_in.out_generation = (handle_ok && is_delete) ? next_gen : tbl_sts.rd_gen;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_chan.data;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // A create must never hand out a slot that is already alive.
   assert property (@(posedge clock) disable iff (reset)
      commit && is_create && tbl_sts.free_found |-> !tbl_sts.rd_alive)
      else $error("create claimed a slot that is alive");

   // A new response appears only after an evaluate cycle committed it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response appeared without a commit");

   // A full table reports an empty handle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STAT_FULL) |->
         (rsp_data_ff.out_slot == '0) && (rsp_data_ff.out_generation == '0)
         && !rsp_data_ff.is_alive)
      else $error("full response carries a handle");

   // A slot is never claimed and freed in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.alive_clr |-> !tbl_cmd.alive_set)
      else $error("slot set and cleared in one cycle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives create, delete and check requests through the request channel under
// changing idle and stall patterns. An in-order scoreboard predicts every
// response from its own copy of the slot table and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
   import gha_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_PER_PHASE = 455;
   localparam int WALK_ROUNDS      = 8;
   localparam int MODE_SPAN        = 120;
   localparam int HOLD_CYCLES      = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_CYCLES     = 20;
   localparam int MAX_REPORTS      = 30;

   // The request code that the package leaves unnamed. It must act as a check.
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   // Scoreboard: keeps a private copy of the alive flags and generations,
   // turns each accepted request into the response the block owes, and
   // matches responses against those expectations in order.
   class handle_scoreboard;
      bit              slot_live [SLOTS];
      gen_type         slot_gen [SLOTS];
      rsp_payload_type pending_rsp [$];
      int              requests, creates_done, table_full, deletes_done, refused;
      int              reserved_seen, checked, errors;

      function new();
         foreach (slot_gen[i]) begin
            slot_gen[i]  = '0;
            slot_live[i] = 1'b0;
         end
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type want;
         int              free_slot;
         bit              valid_handle;
         want = '0;
         requests++;
         if (r.req_type == REQ_RESERVED) reserved_seen++;
         if (r.req_type == REQ_CREATE) begin
            // Lowest free slot wins.
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!slot_live[i]) free_slot = i;
            if (free_slot < 0) begin
               want.status = STAT_FULL;
               table_full++;
            end else begin
               slot_live[free_slot] = 1'b1;
               want.status          = STAT_DONE;
               want.out_slot        = slot_type'(free_slot);
               want.out_generation  = slot_gen[free_slot];
               creates_done++;
            end
         end else begin
            // Delete, check and the reserved code all test the handle first.
            want.out_slot = r.slot_index;
            valid_handle  = (int'(r.slot_index) < SLOTS) && slot_live[r.slot_index]
                            && (slot_gen[r.slot_index] == r.handle_generation);
            if (valid_handle) begin
               want.status   = STAT_DONE;
               want.is_alive = 1'b1;
               if (r.req_type == REQ_DELETE) begin
                  slot_gen[r.slot_index]  = slot_gen[r.slot_index] + gen_type'(1);
                  slot_live[r.slot_index] = 1'b0;
                  deletes_done++;
               end
            end else begin
               want.status = STAT_STALE;
               refused++;
            end
            if (int'(r.slot_index) < SLOTS) want.out_generation = slot_gen[r.slot_index];
         end
         pending_rsp = {pending_rsp, want};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         checked++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with none outstanding, expected nothing, actual %0h",
                        $time, got);
         end else begin
            want = pending_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_slot", 32'(want.out_slot), 32'(got.out_slot));
            compare_field("out_generation", 32'(want.out_generation),
                          32'(got.out_generation));
            compare_field("is_alive", 32'(want.is_alive), 32'(got.is_alive));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   gha_req_if req_if ();
   gha_rsp_if rsp_if ();

   generational_handle_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   handle_scoreboard book = new();

   // Traffic shaping, set by the stimulus thread at falling edges and read by
   // the response sink at rising edges.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_orders   = 0;
   int quiet_cycles  = 0;
   int walk_slot     = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Monitor: both channels are sampled at the rising edge, so every value
   // seen here is the one that settled during the previous half cycle.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) book.note_request(req_if.data);
      if (!reset && rsp_if.valid && rsp_if.ready) book.check_response(rsp_if.data);
   end

   // Watchdog: a run that stops moving on both channels for too long is hung.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Response sink. The decision for the next cycle is taken at the rising
   // edge and applied at the falling edge. A hold order from the stimulus
   // thread turns into a long stretch of back-pressure counted here, which
   // lets the block fill its response register and stop taking requests.
   initial begin : response_sink
      int   hold_left;
      int   holds_taken;
      logic take_next;
      hold_left     = 0;
      holds_taken   = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_orders != holds_taken) begin
            holds_taken = hold_orders;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take_next = 1'b0;
         end else begin
            take_next = ($urandom_range(99) >= rsp_stall_pct);
         end
         @(negedge clock);
         rsp_if.ready <= take_next;
      end
   end

   function automatic req_payload_type make_request(logic [1:0] kind, int slot, int gen);
      req_payload_type r;
      r.req_type          = kind;
      r.slot_index        = slot_type'(slot);
      r.handle_generation = gen_type'(gen);
      return r;
   endfunction

   // Builds one random request from the current table contents. Most requests
   // carry handles that really exist so that deletes and checks get past the
   // handle test; the remainder are stale handles, freed slots and noise.
   function automatic req_payload_type pick_request(int create_pct, int delete_pct);
      req_payload_type r;
      int              live_slots [$];
      int              roll;
      int              s;
      r.req_type          = REQ_CHECK;
      r.slot_index        = slot_type'($urandom);
      r.handle_generation = gen_type'($urandom);
      for (int i = 0; i < SLOTS; i++)
         if (book.slot_live[i]) live_slots = {live_slots, i};
      if (live_slots.size() > 0) s = live_slots[$urandom_range(live_slots.size() - 1)];
      else s = int'(r.slot_index);
      roll = $urandom_range(99);
      if (roll < create_pct) begin
         r.req_type = REQ_CREATE;
      end else if (roll < create_pct + delete_pct) begin
         r = make_request(REQ_DELETE, s, book.slot_gen[s]);
      end else begin
         case ($urandom_range(9))
            0, 1, 2: r = make_request(REQ_CHECK, s, book.slot_gen[s]);
            3: begin
               // A live slot with one generation bit wrong.
               r = make_request($urandom_range(1) ? REQ_DELETE : REQ_CHECK, s,
                                book.slot_gen[s] ^ (1 << $urandom_range(GEN_BITS - 1)));
            end
            4: begin
               // Any slot with its stored generation; a freed slot is refused.
               r.req_type          = $urandom_range(1) ? REQ_DELETE : REQ_CHECK;
               r.handle_generation = book.slot_gen[r.slot_index];
            end
            5: r = make_request(REQ_RESERVED, s, book.slot_gen[s]);
            default: r.req_type = 2'($urandom_range(3));
         endcase
      end
      return r;
   endfunction

   // Offers one request and returns at the falling edge after its transfer.
   // It is always entered at a falling edge with the previous request already
   // taken, so valid is either held high or lowered for an idle gap first.
   task automatic send_request(req_payload_type r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int create_pct;
      int delete_pct;
      int issued;
      issued       = 0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: every request kind on live, stale and freed handles,
      // the extremes of the handle fields, and reuse of the lowest free slot.
      send_request(make_request(REQ_CHECK, 0, 0));           // nothing alive after reset
      send_request(make_request(REQ_CREATE, SLOTS - 1, 16'hFFFF)); // handle fields ignored
      send_request(make_request(REQ_CHECK, 0, 0));           // the new handle is valid
      send_request(make_request(REQ_CHECK, 0, 1));
      send_request(make_request(REQ_CHECK, 0, 16'hFFFF));
      send_request(make_request(REQ_RESERVED, 0, 0));        // acts as a check only
      send_request(make_request(REQ_DELETE, 0, 1));          // wrong generation, no effect
      send_request(make_request(REQ_DELETE, 0, 0));          // frees slot 0, generation 1
      send_request(make_request(REQ_DELETE, 0, 0));          // the same handle a second time
      send_request(make_request(REQ_CHECK, 0, 1));           // freed slot, current generation
      send_request(make_request(REQ_CREATE, 0, 0));          // slot 0 again, generation 1
      send_request(make_request(REQ_CREATE, 0, 0));
      send_request(make_request(REQ_CREATE, 0, 0));
      send_request(make_request(REQ_DELETE, 1, 0));
      send_request(make_request(REQ_CREATE, 0, 0));          // reuses slot 1
      send_request(make_request(REQ_CHECK, SLOTS - 1, 0));
      send_request(make_request(REQ_DELETE, SLOTS - 1, 16'hFFFF));
      send_request(make_request(REQ_RESERVED, SLOTS - 1, 0));
      send_request(make_request(REQ_RESERVED, 1, 1));
      send_request(make_request(REQ_CHECK, 1, 1));           // still alive after that

      // Generation walk: create and delete on one slot a few times so that
      // its generation climbs while the slot is reused each round.
      walk_slot = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--)
         if (!book.slot_live[i]) walk_slot = i;
      for (int n = 0; n < WALK_ROUNDS; n++) begin
         send_request(make_request(REQ_CREATE, $urandom, $urandom));
         send_request(make_request(REQ_DELETE, walk_slot, book.slot_gen[walk_slot]));
      end

      // Random part in four traffic phases. Within each phase the request mix
      // cycles through filling the table to full, a balanced mix and draining.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         // Long back-pressure while requests keep coming at full rate.
         if (phase == 0) hold_orders++;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            case ((issued / MODE_SPAN) % 3)
               0: begin create_pct = 75; delete_pct = 10; end
               1: begin create_pct = 30; delete_pct = 30; end
               default: begin create_pct = 10; delete_pct = 65; end
            endcase
            send_request(pick_request(create_pct, delete_pct));
            issued++;
         end
      end
      req_if.valid <= 1'b0;

      // Let every outstanding response arrive, then watch a little longer for
      // anything the block should not send.
      while (book.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d creates, %0d table full, %0d deletes, %0d refused,",
               book.requests, book.creates_done, book.table_full, book.deletes_done,
               book.refused);
      $display("%0d reserved-code requests, generation walk on slot %0d, %0d responses.",
               book.reserved_seen, walk_slot, book.checked);
      if (book.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
